// ===== sv/dsis_pkg.sv =====
// Shared types and constants of the dual sensor integration sequencer.
// No dependencies; every other file of the block refers to this package.
package dsis_pkg;

   localparam int unsigned TICK_WIDTH   = 32;
   localparam int unsigned PAUSE_WIDTH  = 10;
   localparam int unsigned SAMPLE_WIDTH = 10;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic [TICK_WIDTH-1:0]  PIXEL_COUNT     = 32'd288;
   localparam logic [TICK_WIDTH-1:0]  PREAMBLE_PULSES = 32'd3;
   localparam logic [PAUSE_WIDTH-1:0] PAUSE_RESET     = 10'd87;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INTEG_TICKS_A = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INTEG_TICKS_B = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PAUSE_TICKS   = 2'd2;

   // sensor mask: bit 0 is sensor A, bit 1 is sensor B
   localparam logic [1:0] LONGER_SAME = 2'd0;
   localparam logic [1:0] LONGER_A    = 2'd1;
   localparam logic [1:0] LONGER_B    = 2'd2;
   localparam logic [1:0] SENSOR_BOTH = 2'd3;
   localparam logic [1:0] SENSOR_NONE = 2'd0;

   typedef enum logic [7:0] {
      PH_IDLE       = 8'b0000_0001,
      PH_PRE        = 8'b0000_0010,
      PH_BOTH       = 8'b0000_0100,
      PH_FIRST      = 8'b0000_1000,
      PH_SHORT_REST = 8'b0001_0000,
      PH_LONG_EXTRA = 8'b0010_0000,
      PH_TAIL       = 8'b0100_0000,
      PH_READ       = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic                    start_run;
      logic [SAMPLE_WIDTH-1:0] sample_a;
      logic [SAMPLE_WIDTH-1:0] sample_b;
   } req_type;

   typedef struct packed {
      logic                    clock_a_pulse;
      logic                    clock_b_pulse;
      logic                    start_a_level;
      logic                    start_b_level;
      logic                    pixel_valid;
      logic [SAMPLE_WIDTH-1:0] pixel_a;
      logic [SAMPLE_WIDTH-1:0] pixel_b;
      logic                    pixel_last;
      logic                    busy_res;
   } rsp_type;

   // segment lengths derived from the configuration registers
   typedef struct packed {
      logic [1:0]             longer;
      logic [TICK_WIDTH-1:0]  min_ticks;
      logic [TICK_WIDTH-1:0]  diff_ticks;
      logic [PAUSE_WIDTH-1:0] pause;
      logic [PAUSE_WIDTH-1:0] pause_minus_diff;
      logic [TICK_WIDTH-1:0]  diff_minus_pause;
      logic                   diff_lt_pause;
      logic                   min_zero;
      logic                   pause_zero;
      logic                   diff_minus_pause_zero;
   } timing_type;

   typedef struct packed {
      phase_type             phase;
      logic [TICK_WIDTH-1:0] len;
   } seg_type;

endpackage

// ===== sv/dsis_csr.sv =====
// Configuration registers and the two-stage derivation of segment lengths.
// Depends on dsis_pkg.
module dsis_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   write_en,
   input  logic [dsis_pkg::CSR_INDEX_WIDTH-1:0]   write_index,
   input  logic [dsis_pkg::CSR_DATA_WIDTH-1:0]    write_data,
   output dsis_pkg::timing_type                   timing
);

   logic [dsis_pkg::TICK_WIDTH-1:0]  integ_a_ff;
   logic [dsis_pkg::TICK_WIDTH-1:0]  integ_b_ff;
   logic [dsis_pkg::PAUSE_WIDTH-1:0] pause_ff;

   logic [1:0]                       longer_in, longer_ff;
   logic [dsis_pkg::TICK_WIDTH-1:0]  min_in, min_ff;
   logic [dsis_pkg::TICK_WIDTH-1:0]  diff_in, diff_ff;
   logic [dsis_pkg::PAUSE_WIDTH-1:0] pause_s1_ff;

   dsis_pkg::timing_type             timing_in, timing_ff;
   logic [dsis_pkg::TICK_WIDTH-1:0]  pause_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_a_ff <= '0;
         integ_b_ff <= '0;
         pause_ff   <= dsis_pkg::PAUSE_RESET;
      end else if (write_en) begin
         case (write_index)
            dsis_pkg::REG_INTEG_TICKS_A: integ_a_ff <= write_data;
            dsis_pkg::REG_INTEG_TICKS_B: integ_b_ff <= write_data;
            dsis_pkg::REG_PAUSE_TICKS:   pause_ff   <= write_data[dsis_pkg::PAUSE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (integ_a_ff == integ_b_ff) begin
         longer_in = dsis_pkg::LONGER_SAME;
         min_in    = integ_a_ff;
         diff_in   = '0;
      end else if (integ_b_ff > integ_a_ff) begin
         longer_in = dsis_pkg::LONGER_B;
         min_in    = integ_a_ff;
         diff_in   = integ_b_ff - integ_a_ff;
      end else begin
         longer_in = dsis_pkg::LONGER_A;
         min_in    = integ_b_ff;
         diff_in   = integ_a_ff - integ_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      longer_ff   <= longer_in;
      min_ff      <= min_in;
      diff_ff     <= diff_in;
      pause_s1_ff <= pause_ff;
   end

   assign pause_wide = {{(dsis_pkg::TICK_WIDTH-dsis_pkg::PAUSE_WIDTH){1'b0}}, pause_s1_ff};

   always_comb begin
      timing_in.longer                = longer_ff;
      timing_in.min_ticks             = min_ff;
      timing_in.diff_ticks            = diff_ff;
      timing_in.pause                 = pause_s1_ff;
      timing_in.pause_minus_diff      = pause_s1_ff - diff_ff[dsis_pkg::PAUSE_WIDTH-1:0];
      timing_in.diff_minus_pause      = diff_ff - pause_wide;
      timing_in.diff_lt_pause         = diff_ff < pause_wide;
      timing_in.min_zero              = min_ff == '0;
      timing_in.pause_zero            = pause_s1_ff == '0;
      timing_in.diff_minus_pause_zero = diff_ff == pause_wide;
   end

   always_ff @(posedge clock) begin
      timing_ff <= timing_in;
   end

   assign timing = timing_ff;

endmodule

// ===== sv/dsis_core.sv =====
// Phase register, pulse counter and per-tick result logic of the sequencer.
// Depends on dsis_pkg; timing comes from dsis_csr.
module dsis_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  dsis_pkg::req_type     item,
   input  dsis_pkg::timing_type  timing,
   output dsis_pkg::rsp_type     result
);

   dsis_pkg::phase_type             phase_ff, phase_in, cur_phase;
   logic [dsis_pkg::TICK_WIDTH-1:0] count_ff, count_in, cur_count;
   logic                            seg_done;
   logic [dsis_pkg::TICK_WIDTH-1:0] pause_wide, pmd_wide;
   dsis_pkg::seg_type               after_both, after_pre, after_first, after_long, next_seg;

   assign pause_wide = {{(dsis_pkg::TICK_WIDTH-dsis_pkg::PAUSE_WIDTH){1'b0}}, timing.pause};
   assign pmd_wide   = {{(dsis_pkg::TICK_WIDTH-dsis_pkg::PAUSE_WIDTH){1'b0}},
                        timing.pause_minus_diff};

   always_comb begin
      if (timing.longer == dsis_pkg::LONGER_SAME) begin
         if (timing.pause_zero) begin
            after_both = '{phase: dsis_pkg::PH_READ, len: dsis_pkg::PIXEL_COUNT};
         end else begin
            after_both = '{phase: dsis_pkg::PH_FIRST, len: pause_wide};
         end
      end else if (timing.diff_lt_pause) begin
         after_both = '{phase: dsis_pkg::PH_FIRST, len: timing.diff_ticks};
      end else if (!timing.pause_zero) begin
         after_both = '{phase: dsis_pkg::PH_FIRST, len: pause_wide};
      end else begin
         after_both = '{phase: dsis_pkg::PH_LONG_EXTRA, len: timing.diff_minus_pause};
      end
   end

   always_comb begin
      if (!timing.min_zero) begin
         after_pre = '{phase: dsis_pkg::PH_BOTH, len: timing.min_ticks};
      end else begin
         after_pre = after_both;
      end
   end

   always_comb begin
      if (timing.longer == dsis_pkg::LONGER_SAME) begin
         after_first = '{phase: dsis_pkg::PH_READ, len: dsis_pkg::PIXEL_COUNT};
      end else if (timing.diff_lt_pause) begin
         after_first = '{phase: dsis_pkg::PH_SHORT_REST, len: pmd_wide};
      end else if (!timing.diff_minus_pause_zero) begin
         after_first = '{phase: dsis_pkg::PH_LONG_EXTRA, len: timing.diff_minus_pause};
      end else begin
         after_first = '{phase: dsis_pkg::PH_TAIL, len: pause_wide};
      end
   end

   always_comb begin
      if (!timing.pause_zero) begin
         after_long = '{phase: dsis_pkg::PH_TAIL, len: pause_wide};
      end else begin
         after_long = '{phase: dsis_pkg::PH_READ, len: dsis_pkg::PIXEL_COUNT};
      end
   end

   always_comb begin
      if (phase_ff == dsis_pkg::PH_IDLE && item.start_run) begin
         cur_phase = dsis_pkg::PH_PRE;
         cur_count = dsis_pkg::PREAMBLE_PULSES;
      end else begin
         cur_phase = phase_ff;
         cur_count = count_ff;
      end
      seg_done = cur_count == {{(dsis_pkg::TICK_WIDTH-1){1'b0}}, 1'b1};
   end

   always_comb begin
      case (cur_phase)
         dsis_pkg::PH_PRE:        next_seg = after_pre;
         dsis_pkg::PH_BOTH:       next_seg = after_both;
         dsis_pkg::PH_FIRST:      next_seg = after_first;
         dsis_pkg::PH_SHORT_REST: next_seg = '{phase: dsis_pkg::PH_TAIL,
                                              len: timing.diff_ticks};
         dsis_pkg::PH_LONG_EXTRA: next_seg = after_long;
         dsis_pkg::PH_TAIL:       next_seg = '{phase: dsis_pkg::PH_READ,
                                              len: dsis_pkg::PIXEL_COUNT};
         default:                 next_seg = '{phase: dsis_pkg::PH_IDLE, len: '0};
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (step && cur_phase != dsis_pkg::PH_IDLE) begin
         if (seg_done) begin
            phase_in = next_seg.phase;
            count_in = next_seg.len;
         end else begin
            phase_in = cur_phase;
            count_in = cur_count - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dsis_pkg::PH_IDLE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      logic [1:0] clocks;
      logic [1:0] lines;
      case (cur_phase)
         dsis_pkg::PH_IDLE:       begin clocks = dsis_pkg::SENSOR_NONE; lines = dsis_pkg::SENSOR_NONE; end
         dsis_pkg::PH_BOTH:       begin clocks = dsis_pkg::SENSOR_BOTH; lines = dsis_pkg::SENSOR_BOTH; end
         dsis_pkg::PH_FIRST:      begin clocks = dsis_pkg::SENSOR_BOTH; lines = timing.longer; end
         dsis_pkg::PH_LONG_EXTRA: begin clocks = timing.longer; lines = timing.longer; end
         dsis_pkg::PH_TAIL:       begin clocks = timing.longer; lines = dsis_pkg::SENSOR_NONE; end
         default:                 begin clocks = dsis_pkg::SENSOR_BOTH; lines = dsis_pkg::SENSOR_NONE; end
      endcase
      result.clock_a_pulse = clocks[0];
      result.clock_b_pulse = clocks[1];
      result.start_a_level = lines[0];
      result.start_b_level = lines[1];
      result.pixel_valid   = cur_phase == dsis_pkg::PH_READ;
      result.pixel_a       = (cur_phase == dsis_pkg::PH_READ) ? item.sample_a : '0;
      result.pixel_b       = (cur_phase == dsis_pkg::PH_READ) ? item.sample_b : '0;
      result.pixel_last    = cur_phase == dsis_pkg::PH_READ && seg_done;
      result.busy_res      = cur_phase != dsis_pkg::PH_IDLE;
   end

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff != dsis_pkg::PH_IDLE |-> count_ff != '0)
      else $error("pulse counter empty inside a segment");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      step && result.pixel_last |=> phase_ff == dsis_pkg::PH_IDLE)
      else $error("run did not end after last pixel");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> phase_ff == $past(phase_ff) && count_ff == $past(count_ff))
      else $error("state moved without a tick");

   a_last_in_read: assert property (@(posedge clock) disable iff (reset)
      result.pixel_last |-> result.pixel_valid && result.busy_res)
      else $error("last pixel flagged outside readout");

endmodule

// ===== sv/dual_sensor_integration_sequencer.sv =====
// Top level of the dual sensor integration sequencer: handshakes and word registers.
// Depends on dsis_pkg, dsis_csr and dsis_core.
//
// Usage: every word on the req_ channel is one sensor clock tick and yields exactly
// one word on the rsp_ channel, giving the clock pulses and start-line levels of both
// sensors for that tick and, during readout, the sample pair with a last-pixel flag.
// A word with start_run set begins a run while idle and is the first preamble pulse.
// Configuration is written through the csr_ channel (index 0 integration A, 1
// integration B, 2 pause), which is always ready; write only between runs. Derived
// segment lengths settle inside the preamble, after a write has passed the configuration
// register and both derivation stages. A request passes the input, then the result register.
// Throughput: one word per cycle while the receiver is ready; the phase register and pulse counter update once
// per tick, and the input and result registers let a new request in while a result
// still waits. When the receiver stalls, the result register holds, then the input
// register fills and req_ready drops; nothing is lost or repeated.
// Reset: both word registers empty, sequencer idle, integration times 0, pause 87.
module dual_sensor_integration_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  dsis_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output dsis_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dsis_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dsis_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   logic                 in_valid_ff, in_valid_in;
   dsis_pkg::req_type    in_ff;
   logic                 out_valid_ff, out_valid_in;
   dsis_pkg::rsp_type    out_ff;
   logic                 process;
   dsis_pkg::timing_type timing;
   dsis_pkg::rsp_type    result;

   assign csr_ready = 1'b1;
   assign process   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || process;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !process);
   assign out_valid_in = process || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (process) begin
         out_ff <= result;
      end
   end

   dsis_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .write_en    (csr_valid && csr_ready),
      .write_index (csr_index),
      .write_data  (csr_data),
      .timing      (timing)
   );

   dsis_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (process),
      .item   (in_ff),
      .timing (timing),
      .result (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !process)
      else $error("result word overwritten while stalled");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process |-> !req_ready)
      else $error("request taken into a full input register");

   a_word_moves: assert property (@(posedge clock) disable iff (reset)
      process |=> out_valid_ff)
      else $error("processed word missing from result register");

endmodule
